@@ src/rrfp_pkg.sv @@
`default_nettype none
package rrfp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned DIST_W  = 20;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned INDEX_W = 1;

   localparam logic [BYTE_W-1:0] HEADER_FIRST  = 8'h54;
   localparam logic [BYTE_W-1:0] HEADER_SECOND = 8'h48;
   localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;
   localparam logic [WORD_W-1:0] RAW_NONE      = 16'hFFFF;

   localparam logic [POS_W-1:0] POS_HEADER_FIRST  = 5'd0;
   localparam logic [POS_W-1:0] POS_HEADER_SECOND = 5'd1;
   localparam logic [POS_W-1:0] POS_WORD_HIGH     = 5'd2;
   localparam logic [POS_W-1:0] POS_WORD_LOW      = 5'd3;
   localparam logic [POS_W-1:0] FRAME_SHORT       = 5'd18;
   localparam logic [POS_W-1:0] FRAME_LONG        = 5'd19;

   localparam logic [INDEX_W-1:0] REG_LONG_FRAME   = 1'b0;
   localparam logic [INDEX_W-1:0] REG_MIN_DISTANCE = 1'b1;

   // good-frame event from the parser to the range stage
   typedef struct packed {
      logic              frame_good;
      logic [WORD_W-1:0] range_word;
   } frame_event_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/rrfp_parse.sv @@
`default_nettype none
module rrfp_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [rrfp_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic                          long_frame,
   output rrfp_pkg::frame_event_type          frame_event
);
   import rrfp_pkg::*;

   logic [POS_W-1:0]  pos_ff,  pos_in;
   logic [BYTE_W-1:0] crc_ff,  crc_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [POS_W-1:0]  frame_len;
   logic [BYTE_W-1:0] crc_next;

   assign frame_len = long_frame ? FRAME_LONG : FRAME_SHORT;
   assign crc_next  = crc8_byte(crc_ff, rx_byte);

   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      word_in = word_ff;
      frame_event.frame_good = 1'b0;
      frame_event.range_word = word_ff;
      priority if (pos_ff == POS_HEADER_FIRST || pos_ff == POS_HEADER_SECOND) begin
         if (rx_byte == ((pos_ff == POS_HEADER_FIRST) ? HEADER_FIRST : HEADER_SECOND)) begin
            crc_in = crc_next;
            pos_in = pos_ff + 1'b1;
         end else begin
            crc_in = '0;
            pos_in = '0;
         end
      end else if (pos_ff < frame_len) begin
         if (pos_ff == POS_WORD_HIGH) begin
            word_in = {rx_byte, word_ff[BYTE_W-1:0]};
         end else if (pos_ff == POS_WORD_LOW) begin
            word_in = {word_ff[WORD_W-1:BYTE_W], rx_byte};
         end
         crc_in = crc_next;
         pos_in = pos_ff + 1'b1;
      end else begin
         // check byte closes the frame either way
         frame_event.frame_good = (rx_byte == crc_ff);
         crc_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         crc_ff  <= '0;
         word_ff <= '0;
      end else if (fire) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

@@ src/rrfp_range.sv @@
`default_nettype none
module rrfp_range (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire rrfp_pkg::frame_event_type     frame_event,
   input  wire logic                          long_frame,
   input  wire logic [rrfp_pkg::DIST_W-1:0]   min_distance_mm,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_target_available,
   output logic [rrfp_pkg::DIST_W-1:0]        rsp_distance_mm
);
   import rrfp_pkg::*;

   logic              valid_ff,     valid_in;
   logic              available_ff, available_in;
   logic [DIST_W-1:0] distance_ff,  distance_in;
   logic [WORD_W-1:0] raw;
   logic [DIST_W-1:0] raw_ext;
   logic [DIST_W-1:0] range_mm;
   logic              load;

   assign raw      = (frame_event.range_word == RAW_NONE) ? '0 : frame_event.range_word;
   assign raw_ext  = {{(DIST_W-WORD_W){1'b0}}, raw};
   // x10 as x8 + x2
   assign range_mm = long_frame ? raw_ext : ((raw_ext << 3) + (raw_ext << 1));

   assign load         = fire && frame_event.frame_good;
   assign available_in = range_mm > min_distance_mm;
   assign distance_in  = available_in ? range_mm : '0;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         available_ff <= available_in;
         distance_ff  <= distance_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_target_available = available_ff;
   assign rsp_distance_mm      = distance_ff;

endmodule
`default_nettype wire

@@ src/radar_range_frame_parser.sv @@
`default_nettype none
// channel | direction | handshake          | payload
// req     | in        | req_valid/stall    | req_rx_byte[7:0]
// rsp     | out       | rsp_valid/stall    | rsp_target_available, rsp_distance_mm[19:0]
// csr     | in        | csr_write          | csr_index[0], csr_data[19:0]
//
// One byte per cycle sustained while the result side does not stall. A byte is
// held in the input register; when it fires, the byte-wide CRC and position update
// and the distance/threshold logic put any result into the output register.
// Synchronous reset clears the frame hunt, the CRC and the valid flags of both registers.
// A stalled result holds the output and the input register; req_stall is low whenever
// the output register is empty or being taken.
module radar_range_frame_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rrfp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_target_available,
   output logic [rrfp_pkg::DIST_W-1:0]        rsp_distance_mm,
   input  wire logic                          csr_write,
   input  wire logic [rrfp_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [rrfp_pkg::DIST_W-1:0]   csr_data
);
   import rrfp_pkg::*;

   logic              long_frame_ff;
   logic [DIST_W-1:0] min_distance_ff;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_free;
   logic              fire;
   logic              take;
   frame_event_type   frame_event;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_frame_ff   <= 1'b0;
         min_distance_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LONG_FRAME:   long_frame_ff   <= csr_data[0];
            REG_MIN_DISTANCE: min_distance_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   rrfp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .rx_byte     (in_byte_ff),
      .long_frame  (long_frame_ff),
      .frame_event (frame_event)
   );

   rrfp_range u_range (
      .clock                (clock),
      .reset                (reset),
      .fire                 (fire),
      .frame_event          (frame_event),
      .long_frame           (long_frame_ff),
      .min_distance_mm      (min_distance_ff),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_target_available (rsp_target_available),
      .rsp_distance_mm      (rsp_distance_mm)
   );

endmodule
`default_nettype wire

@@ verif/radar_range_frame_parser_tb.sv @@
`timescale 1ns / 1ps

module radar_range_frame_parser_tb;
   import rrfp_pkg::*;

   localparam int WATCHDOG_LIMIT     = 3000;
   localparam int HOLD_CYCLES        = 400;
   localparam int SETTLE_CYCLES      = 4;
   localparam int RANDOM_FRAME_BYTES = 1350;
   localparam int PHASE_BYTES        = 200;
   localparam int MM_PER_SHORT_UNIT  = 10;
   localparam logic [DIST_W-1:0] MAX_MIN_MM = 20'd655350;

   typedef struct packed {
      logic              available;
      logic [DIST_W-1:0] dist_mm;
   } range_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_target_available;
   logic [DIST_W-1:0]   rsp_distance_mm;
   logic                csr_write;
   logic [INDEX_W-1:0]  csr_index;
   logic [DIST_W-1:0]   csr_data;

   // parser mirror: configuration and frame state
   logic                cfg_long;
   logic [DIST_W-1:0]   cfg_min_mm;
   logic [POS_W-1:0]    mdl_pos;
   logic [BYTE_W-1:0]   mdl_crc;
   logic [WORD_W-1:0]   mdl_word;
   range_result_type    pending_ranges[$];

   int errors      = 0;
   int idle_cycles = 0;
   bit steady      = 1'b0;
   bit hold_req    = 1'b0;

   radar_range_frame_parser uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_target_available (rsp_target_available),
      .rsp_distance_mm      (rsp_distance_mm),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // bitwise CRC-8, MSB first
   function automatic logic [BYTE_W-1:0] crc_next(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = BYTE_W-1; i >= 0; i--) begin
         fb = c[BYTE_W-1] ^ data[i];
         c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic void parse_byte(input logic [BYTE_W-1:0] b);
      logic [POS_W-1:0]  flen;
      logic [BYTE_W-1:0] want_hdr;
      logic [DIST_W-1:0] range_mm;
      range_result_type  r;
      flen = cfg_long ? FRAME_LONG : FRAME_SHORT;
      if (mdl_pos < POS_WORD_HIGH) begin
         want_hdr = (mdl_pos == POS_HEADER_FIRST) ? HEADER_FIRST : HEADER_SECOND;
         if (b != want_hdr) begin
            mdl_pos = POS_HEADER_FIRST;
            mdl_crc = '0;
         end else begin
            mdl_crc = crc_next(mdl_crc, b);
            mdl_pos = mdl_pos + 1'b1;
         end
      end else if (mdl_pos < flen) begin
         if (mdl_pos == POS_WORD_HIGH) begin
            mdl_word[15:8] = b;
         end else if (mdl_pos == POS_WORD_LOW) begin
            mdl_word[7:0] = b;
         end
         mdl_crc = crc_next(mdl_crc, b);
         mdl_pos = mdl_pos + 1'b1;
      end else begin
         // check byte: result only on a CRC match
         if (b == mdl_crc) begin
            range_mm = (mdl_word == RAW_NONE) ? '0 : {{(DIST_W-WORD_W){1'b0}}, mdl_word};
            if (!cfg_long) begin
               range_mm = DIST_W'(range_mm * MM_PER_SHORT_UNIT);
            end
            r.available = (range_mm > cfg_min_mm);
            r.dist_mm   = r.available ? range_mm : '0;
            pending_ranges.push_back(r);
         end
         mdl_pos = POS_HEADER_FIRST;
         mdl_crc = '0;
      end
   endfunction

   // check results, then predict the accepted byte, then apply register writes
   always @(posedge clock) begin
      range_result_type want;
      if (reset) begin
         cfg_long   = 1'b0;
         cfg_min_mm = '0;
         mdl_pos    = POS_HEADER_FIRST;
         mdl_crc    = '0;
         mdl_word   = '0;
         pending_ranges.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ranges.size() == 0) begin
               $error("unexpected result: target_available %0d, distance_mm %0d",
                      rsp_target_available, rsp_distance_mm);
               errors++;
            end else begin
               want = pending_ranges.pop_front();
               if (rsp_target_available !== want.available) begin
                  $error("target_available: expected %0d, got %0d",
                         want.available, rsp_target_available);
                  errors++;
               end
               if (rsp_distance_mm !== want.dist_mm) begin
                  $error("distance_mm: expected %0d, got %0d", want.dist_mm, rsp_distance_mm);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
         end
         if (csr_write) begin
            case (csr_index)
               REG_LONG_FRAME:   cfg_long   = csr_data[0];
               REG_MIN_DISTANCE: cfg_min_mm = csr_data;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("radar_range_frame_parser_tb: done, errors");
            $finish;
         end
      end
   end

   // result side: random stall per result, long hold-off on request
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            wait_cycles = steady ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !hold_req);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // header, range word, random filler; returns the CRC over what was sent
   task automatic send_frame_body(input logic [WORD_W-1:0] word, input int count,
                                  output logic [BYTE_W-1:0] crc);
      logic [BYTE_W-1:0] b;
      crc = '0;
      for (int i = 0; i < count; i++) begin
         case (POS_W'(i))
            POS_HEADER_FIRST:  b = HEADER_FIRST;
            POS_HEADER_SECOND: b = HEADER_SECOND;
            POS_WORD_HIGH:     b = word[15:8];
            POS_WORD_LOW:      b = word[7:0];
            default:           b = BYTE_W'($urandom_range(0, 255));
         endcase
         crc = crc_next(crc, b);
         send_byte(b);
      end
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] word, input bit bad_crc);
      logic [BYTE_W-1:0] crc;
      logic [BYTE_W-1:0] flip;
      send_frame_body(word, cfg_long ? FRAME_LONG : FRAME_SHORT, crc);
      flip = bad_crc ? BYTE_W'($urandom_range(1, 255)) : '0;
      send_byte(crc ^ flip);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   // stop offering, wait for all results, then let bytes with no result clear
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input bit long_frame, input logic [DIST_W-1:0] min_mm);
      csr_write <= 1'b1;
      csr_index <= REG_LONG_FRAME;
      csr_data  <= DIST_W'(long_frame);
      @(negedge clock);
      csr_index <= REG_MIN_DISTANCE;
      csr_data  <= min_mm;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_short_extremes();
      set_config(1'b0, '0);
      send_frame(16'h0000, 1'b0);
      send_frame(16'h0001, 1'b0);
      send_frame(RAW_NONE, 1'b0);
      send_frame(16'hFFFE, 1'b0);
      send_frame(16'hA55A, 1'b0);
      drain();
      set_config(1'b0, MAX_MIN_MM);
      send_frame(16'hFFFE, 1'b0);
      drain();
   endtask

   task automatic test_header_hunt();
      set_config(1'b0, 20'd100);
      // repeated first header byte: the extra one is dropped, frame is lost
      send_byte(HEADER_FIRST);
      send_frame(16'h1234, 1'b0);
      send_byte(8'h00);
      send_byte(HEADER_SECOND);
      send_byte(HEADER_FIRST);
      send_byte(8'h00);
      send_frame(16'h1234, 1'b0);
      drain();
   endtask

   task automatic test_crc_mismatch();
      set_config(1'b0, '0);
      send_frame(16'h0100, 1'b1);
      send_frame(16'h0100, 1'b0);
      drain();
   endtask

   task automatic test_long_mode();
      set_config(1'b1, '0);
      send_frame(16'hFFFE, 1'b0);
      send_frame(RAW_NONE, 1'b0);
      send_frame(16'h0001, 1'b0);
      drain();
      set_config(1'b1, 20'd1000);
      send_frame(16'd1000, 1'b0);
      send_frame(16'd1001, 1'b0);
      drain();
      set_config(1'b1, MAX_MIN_MM);
      send_frame(16'hFFFE, 1'b0);
      drain();
   endtask

   task automatic test_mode_switch_mid_frame();
      logic [BYTE_W-1:0] crc;
      logic [BYTE_W-1:0] b;
      // long body complete, short mode then sees the check byte
      set_config(1'b1, '0);
      send_frame_body(16'h0203, FRAME_LONG, crc);
      drain();
      set_config(1'b0, '0);
      send_byte(crc);
      drain();
      // short body complete, long mode wants one more data byte
      send_frame_body(16'h0405, FRAME_SHORT, crc);
      drain();
      set_config(1'b1, '0);
      b   = BYTE_W'($urandom_range(0, 255));
      crc = crc_next(crc, b);
      send_byte(b);
      send_byte(crc);
      drain();
   endtask

   task automatic test_output_backpressure();
      set_config(1'b0, '0);
      steady   = 1'b1;
      hold_req = 1'b1;
      repeat (6) send_frame(WORD_W'($urandom_range(0, 65535)), 1'b0);
      steady = 1'b0;
      drain();
   endtask

   task automatic test_sender_pause();
      set_config(1'b0, 20'd5000);
      repeat (3) begin
         send_frame(WORD_W'($urandom_range(0, 65535)), 1'b0);
         drain();
      end
   endtask

   task automatic test_random_traffic();
      int                frame_bytes;
      int                phase_len;
      int                pick;
      int                flen;
      int                cut;
      bit                long_frame;
      logic [DIST_W-1:0] min_mm;
      logic [WORD_W-1:0] word;
      logic [BYTE_W-1:0] crc;
      frame_bytes = 0;
      while (frame_bytes < RANDOM_FRAME_BYTES) begin
         drain();
         long_frame = $urandom_range(0, 1);
         case ($urandom_range(0, 4))
            0:       min_mm = '0;
            1:       min_mm = MAX_MIN_MM;
            2:       min_mm = DIST_W'($urandom_range(0, MAX_MIN_MM));
            default: min_mm = DIST_W'($urandom_range(0, long_frame ? 65535 : MAX_MIN_MM));
         endcase
         set_config(long_frame, min_mm);
         steady    = ($urandom_range(0, 3) == 0);
         flen      = long_frame ? FRAME_LONG : FRAME_SHORT;
         phase_len = 0;
         while (phase_len < PHASE_BYTES) begin
            case ($urandom_range(0, 7))
               0:       word = '0;
               1:       word = RAW_NONE;
               2:       word = 16'hFFFE;
               default: word = WORD_W'($urandom_range(0, 65535));
            endcase
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
               send_frame(word, 1'b0);
               phase_len += flen + 1;
            end else if (pick == 7) begin
               send_frame(word, 1'b1);
               phase_len += flen + 1;
            end else if (pick == 8) begin
               send_noise($urandom_range(1, 6));
            end else begin
               // cut-off frame; whatever follows lands mid-frame
               cut = $urandom_range(1, flen - 1);
               send_frame_body(word, cut, crc);
               phase_len += cut;
            end
         end
         frame_bytes += phase_len;
      end
      steady = 1'b0;
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_write   = 1'b0;
      csr_index   = REG_LONG_FRAME;
      csr_data    = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_extremes();
      test_header_hunt();
      test_crc_mismatch();
      test_long_mode();
      test_mode_switch_mid_frame();
      test_output_backpressure();
      test_sender_pause();
      test_random_traffic();

      drain();
      repeat (20) @(negedge clock);
      if (pending_ranges.size() != 0) begin
         $error("%0d expected results never arrived", pending_ranges.size());
         errors++;
      end
      if (errors == 0) begin
         $display("radar_range_frame_parser_tb: done, clean");
      end else begin
         $display("radar_range_frame_parser_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/rrfp_pkg.sv
src/rrfp_parse.sv
src/rrfp_range.sv
src/radar_range_frame_parser.sv
verif/radar_range_frame_parser_tb.sv
